// ===== rtl/core/fcdd_pkg.sv =====
// Shared types and constants for the framed command differential drive block.
// No dependencies; every other file in rtl/core except fcdd_stream_if imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fcdd_pkg;

  // Frame geometry: three stored bytes between start and end
  localparam int FRAME_BYTES = 3;
  localparam int IDX_W       = $clog2(FRAME_BYTES + 1);

  // Reset values for the configuration registers and the servo commands
  localparam logic [7:0] START_BYTE_RST = 8'h30;
  localparam logic [7:0] END_BYTE_RST   = 8'h5A;
  localparam logic [6:0] DEADBAND_RST   = 7'd10;
  localparam logic [7:0] SERVO_RST      = 8'd127;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_END_BYTE   = 2'd1,
    CFG_DEADBAND   = 2'd2
  } cfg_idx_t;

  // Two-byte instruction codes
  localparam logic [15:0] CMD_LEFT_DUTY  = 16'h4141;
  localparam logic [15:0] CMD_RIGHT_DUTY = 16'h4242;
  localparam logic [15:0] CMD_SERVO_X    = 16'h4343;
  localparam logic [15:0] CMD_SERVO_Y    = 16'h4444;
  localparam logic [15:0] CMD_EE_READ    = 16'h4545;
  localparam logic [15:0] CMD_EE_WRITE   = 16'h4646;
  localparam logic [15:0] CMD_MANUAL_ON  = 16'h4747;
  localparam logic [15:0] CMD_MANUAL_OFF = 16'h4848;

  // Motor direction codes
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  // Result event codes
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DONE     = 3'd1,
    EV_EE_READ  = 3'd2,
    EV_EE_WRITE = 3'd3,
    EV_UNKNOWN  = 3'd4,
    EV_JOY_OK   = 3'd5,
    EV_JOY_SKIP = 3'd6
  } ev_t;

  // Input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_JOY  = 1'b1;

  // One motor in sign-magnitude form
  typedef struct packed {
    logic [7:0] duty;
    dir_t       dir;
  } motor_t;

  // Mixer result for both motors
  typedef struct packed {
    motor_t left;
    motor_t right;
  } drive_t;

  // Decoded frame command towards the top level
  typedef struct packed {
    logic       run;
    ev_t        ev;
    logic       set_left;
    logic       set_right;
    logic       set_sx;
    logic       set_sy;
    logic       set_man;
    logic       man_val;
    logic [7:0] data;
  } frame_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/fcdd_stream_if.sv =====
// Valid/ready channel interfaces for the input words and the result words.
// Stand-alone; widths follow the fixed field widths of the block.
`timescale 1ns / 1ps
`default_nettype none

interface fcdd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic [7:0] joy_translate;
  logic [7:0] joy_rotate;
  logic [7:0] joy_servo_x;
  logic [7:0] joy_servo_y;

  modport source (
    output valid, op, rx_byte, joy_translate, joy_rotate, joy_servo_x, joy_servo_y,
    input  ready
  );
  modport sink (
    input  valid, op, rx_byte, joy_translate, joy_rotate, joy_servo_x, joy_servo_y,
    output ready
  );
endinterface

interface fcdd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_duty;
  logic [1:0] left_dir;
  logic [7:0] right_duty;
  logic [1:0] right_dir;
  logic [7:0] servo_x_cmd;
  logic [7:0] servo_y_cmd;
  logic       manual_on;
  logic [2:0] event_res;
  logic [7:0] request_block;

  modport source (
    output valid, left_duty, left_dir, right_duty, right_dir, servo_x_cmd,
           servo_y_cmd, manual_on, event_res, request_block,
    input  ready
  );
  modport sink (
    input  valid, left_duty, left_dir, right_duty, right_dir, servo_x_cmd,
           servo_y_cmd, manual_on, event_res, request_block,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/fcdd_frame.sv =====
// Frame assembler and instruction decoder: byte store, index and command decode.
// Depends on fcdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcdd_frame
  import fcdd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] start_byte,
  input  wire logic [7:0] end_byte,
  output frame_cmd_t      cmd
);

  logic [7:0]       store_r [FRAME_BYTES];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             is_start, do_run, do_store;
  logic [15:0]      instr;

  // Classify the byte: start wins over end, extra bytes are dropped
  always_comb begin
    is_start = (rx_byte == start_byte);
    do_run   = !is_start && (rx_byte == end_byte) && (idx_r == IDX_W'(FRAME_BYTES));
    do_store = !is_start && !do_run && (idx_r < IDX_W'(FRAME_BYTES));
    idx_nxt  = idx_r;
    if (step) begin
      if (is_start) begin
        idx_nxt = '0;
      end else if (do_store) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  // Index register; stays at full after a frame so a repeated end reruns it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Byte store, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (step && do_store && (idx_r == IDX_W'(i))) begin
        store_r[i] <= rx_byte;
      end
    end
  end

  // Instruction decode
  assign instr = {store_r[0], store_r[1]};

  always_comb begin
    cmd           = '0;
    cmd.run       = do_run;
    cmd.data      = store_r[FRAME_BYTES-1];
    cmd.ev        = EV_DONE;
    unique case (instr)
      CMD_LEFT_DUTY:  cmd.set_left  = 1'b1;
      CMD_RIGHT_DUTY: cmd.set_right = 1'b1;
      CMD_SERVO_X:    cmd.set_sx    = 1'b1;
      CMD_SERVO_Y:    cmd.set_sy    = 1'b1;
      CMD_EE_READ:    cmd.ev        = EV_EE_READ;
      CMD_EE_WRITE:   cmd.ev        = EV_EE_WRITE;
      CMD_MANUAL_ON: begin
        cmd.set_man = 1'b1;
        cmd.man_val = 1'b1;
      end
      CMD_MANUAL_OFF: begin
        cmd.set_man = 1'b1;
        cmd.man_val = 1'b0;
      end
      default:        cmd.ev        = EV_UNKNOWN;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/fcdd_mix.sv =====
// Differential mixer: centre offset, deadband test, sum/difference, clamp, sign-magnitude.
// Depends on fcdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcdd_mix
  import fcdd_pkg::*;
(
  input  wire logic [7:0] joy_translate,
  input  wire logic [7:0] joy_rotate,
  input  wire logic [6:0] deadband,
  output drive_t          drive
);

  logic signed [7:0] t_off, r_off;
  logic signed [8:0] t_ext, r_ext, t_mag, r_mag;
  logic signed [9:0] diff, sum;
  logic              in_band;

  // Clamp to +/-255 and split into direction and magnitude
  function automatic motor_t to_motor(input logic signed [9:0] v);
    logic signed [9:0] c;
    motor_t            m;
    c = v;
    if (v > 10'sd255) begin
      c = 10'sd255;
    end else if (v < -10'sd255) begin
      c = -10'sd255;
    end
    if (c[9]) begin
      m.dir  = DIR_BACK;
      m.duty = 8'(-c);
    end else begin
      m.dir  = DIR_FWD;
      m.duty = c[7:0];
    end
    return m;
  endfunction

  // Removing the 128 centre offset is a flip of the top bit
  assign t_off = {~joy_translate[7], joy_translate[6:0]};
  assign r_off = {~joy_rotate[7], joy_rotate[6:0]};
  assign t_ext = {t_off[7], t_off};
  assign r_ext = {r_off[7], r_off};

  // Magnitudes for the deadband test
  assign t_mag   = t_ext[8] ? -t_ext : t_ext;
  assign r_mag   = r_ext[8] ? -r_ext : r_ext;
  assign in_band = (t_mag < $signed({2'b00, deadband})) &&
                   (r_mag < $signed({2'b00, deadband}));

  assign diff = {t_ext[8], t_ext} - {r_ext[8], r_ext};
  assign sum  = {t_ext[8], t_ext} + {r_ext[8], r_ext};

  always_comb begin
    if (in_band) begin
      drive.left.duty  = '0;
      drive.left.dir   = DIR_STOP;
      drive.right.duty = '0;
      drive.right.dir  = DIR_STOP;
    end else begin
      drive.left  = to_motor(diff);
      drive.right = to_motor(sum);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/framed_command_differential_drive.sv =====
// Top level: input register, frame decoder, mixer, drive state and result register.
// Depends on fcdd_pkg, fcdd_stream_if, fcdd_frame and fcdd_mix.
//
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | op, rx_byte, joy_translate/rotate/servo_x/servo_y
//   out_ch   | out | valid/ready        | duties, dirs, servos, manual_on, event_res, block
//   cfg_*    | in  | cfg_we, no ready   | cfg_idx selects start, end or deadband
//
// Each word passes through the input register and then the result register, and one
// word a cycle is accepted when out_ch.ready stays high. The result register is the
// drive state itself plus event and block.
// A stalled result holds the input register; in_ch.ready drops only when both fill.
// Synchronous active-low reset clears control and drive state; the frame store
// is left unreset.
`timescale 1ns / 1ps
`default_nettype none

module framed_command_differential_drive
  import fcdd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  fcdd_in_if.sink         in_ch,
  fcdd_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [7:0] cfg_wdata
);

  // Configuration registers
  logic [7:0] start_byte_r, end_byte_r;
  logic [6:0] deadband_r;

  // Input register
  logic       in_vld_r;
  logic       op_r;
  logic [7:0] rx_r, jt_r, jr_r, jsx_r, jsy_r;

  // Drive state and result register
  logic       out_vld_r, out_vld_nxt;
  logic [7:0] left_duty_r, left_duty_nxt, right_duty_r, right_duty_nxt;
  dir_t       left_dir_r, left_dir_nxt, right_dir_r, right_dir_nxt;
  logic [7:0] servo_x_r, servo_x_nxt, servo_y_r, servo_y_nxt;
  logic       manual_r, manual_nxt;
  ev_t        ev_r, ev_nxt;
  logic [7:0] block_r, block_nxt;

  logic       adv, in_take;
  frame_cmd_t cmd;
  drive_t     drive;

  // Stage handshake
  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      end_byte_r   <= END_BYTE_RST;
      deadband_r   <= DEADBAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_START_BYTE: start_byte_r <= cfg_wdata;
        CFG_END_BYTE:   end_byte_r   <= cfg_wdata;
        CFG_DEADBAND:   deadband_r   <= cfg_wdata[6:0];
        default:        ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r  <= in_ch.op;
      rx_r  <= in_ch.rx_byte;
      jt_r  <= in_ch.joy_translate;
      jr_r  <= in_ch.joy_rotate;
      jsx_r <= in_ch.joy_servo_x;
      jsy_r <= in_ch.joy_servo_y;
    end
  end

  fcdd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv && (op_r == OP_BYTE)),
    .rx_byte    (rx_r),
    .start_byte (start_byte_r),
    .end_byte   (end_byte_r),
    .cmd        (cmd)
  );

  fcdd_mix u_mix (
    .joy_translate (jt_r),
    .joy_rotate    (jr_r),
    .deadband      (deadband_r),
    .drive         (drive)
  );

  // Next drive state and result for the word in the input register
  always_comb begin
    left_duty_nxt  = left_duty_r;
    left_dir_nxt   = left_dir_r;
    right_duty_nxt = right_duty_r;
    right_dir_nxt  = right_dir_r;
    servo_x_nxt    = servo_x_r;
    servo_y_nxt    = servo_y_r;
    manual_nxt     = manual_r;
    ev_nxt         = ev_r;
    block_nxt      = block_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    if (adv) begin
      out_vld_nxt = 1'b1;
      ev_nxt      = EV_NONE;
      block_nxt   = '0;
      if (op_r == OP_BYTE) begin
        if (cmd.run) begin
          ev_nxt    = cmd.ev;
          block_nxt = cmd.data;
          if (cmd.set_left)  left_duty_nxt  = cmd.data;
          if (cmd.set_right) right_duty_nxt = cmd.data;
          if (cmd.set_sx)    servo_x_nxt    = cmd.data;
          if (cmd.set_sy)    servo_y_nxt    = cmd.data;
          if (cmd.set_man)   manual_nxt     = cmd.man_val;
        end
      end else if (manual_r) begin
        servo_x_nxt    = jsx_r;
        servo_y_nxt    = jsy_r;
        left_duty_nxt  = drive.left.duty;
        left_dir_nxt   = drive.left.dir;
        right_duty_nxt = drive.right.duty;
        right_dir_nxt  = drive.right.dir;
        ev_nxt         = EV_JOY_OK;
      end else begin
        ev_nxt = EV_JOY_SKIP;
      end
    end
  end

  // Drive state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r    <= 1'b0;
      left_duty_r  <= '0;
      left_dir_r   <= DIR_STOP;
      right_duty_r <= '0;
      right_dir_r  <= DIR_STOP;
      servo_x_r    <= SERVO_RST;
      servo_y_r    <= SERVO_RST;
      manual_r     <= 1'b1;
      ev_r         <= EV_NONE;
      block_r      <= '0;
    end else begin
      out_vld_r    <= out_vld_nxt;
      left_duty_r  <= left_duty_nxt;
      left_dir_r   <= left_dir_nxt;
      right_duty_r <= right_duty_nxt;
      right_dir_r  <= right_dir_nxt;
      servo_x_r    <= servo_x_nxt;
      servo_y_r    <= servo_y_nxt;
      manual_r     <= manual_nxt;
      ev_r         <= ev_nxt;
      block_r      <= block_nxt;
    end
  end

  // Result channel
  assign out_ch.valid         = out_vld_r;
  assign out_ch.left_duty     = left_duty_r;
  assign out_ch.left_dir      = left_dir_r;
  assign out_ch.right_duty    = right_duty_r;
  assign out_ch.right_dir     = right_dir_r;
  assign out_ch.servo_x_cmd   = servo_x_r;
  assign out_ch.servo_y_cmd   = servo_y_r;
  assign out_ch.manual_on     = manual_r;
  assign out_ch.event_res     = ev_r;
  assign out_ch.request_block = block_r;

endmodule

`default_nettype wire

// ===== rtl/core/fcdd_chk.sv =====
// Port-level checker for the drive block and its bind to the top level.
// Depends on fcdd_pkg and framed_command_differential_drive.
`timescale 1ns / 1ps
`default_nettype none

module fcdd_chk
  import fcdd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] left_duty,
  input wire logic [1:0] left_dir,
  input wire logic [7:0] right_duty,
  input wire logic [1:0] right_dir,
  input wire logic       manual_on,
  input wire logic [2:0] event_res,
  input wire logic [7:0] request_block
);

  // A stalled result word holds its drive fields
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_duty) && $stable(left_dir) &&
      $stable(right_duty) && $stable(right_dir) && $stable(manual_on))
    else $error("result word changed while stalled");

  // An ignored joystick word only happens in automatic mode
  a_skip_auto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_JOY_SKIP) |-> !manual_on)
    else $error("joystick ignored while manual mode on");

  // Deadband stop hits both motors together with zero duty
  a_band_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_JOY_OK) && (left_dir == DIR_STOP) |->
      (right_dir == DIR_STOP) && (left_duty == 8'd0) && (right_duty == 8'd0))
    else $error("deadband stop not applied to both motors");

  // Block byte is only shown for a completed frame
  a_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((event_res == EV_NONE) || (event_res == EV_JOY_OK) ||
      (event_res == EV_JOY_SKIP)) |-> (request_block == 8'd0))
    else $error("request block set without a frame");

endmodule

bind framed_command_differential_drive fcdd_chk u_fcdd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .left_duty     (out_ch.left_duty),
  .left_dir      (out_ch.left_dir),
  .right_duty    (out_ch.right_duty),
  .right_dir     (out_ch.right_dir),
  .manual_on     (out_ch.manual_on),
  .event_res     (out_ch.event_res),
  .request_block (out_ch.request_block)
);

`default_nettype wire

// ===== verif/fcdd_drive_checker.sv =====
// Checker for the framed command differential drive block: watches the input, result
// and register write ports, predicts every result word and compares it field by field.
// Depends on fcdd_pkg and the channel interfaces in fcdd_stream_if.
`timescale 1ns / 1ps

module fcdd_drive_checker
  import fcdd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  fcdd_in_if         in_mon,
  fcdd_out_if        out_mon,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_wdata,
  output int         mismatches,
  output int         outstanding,
  output int         words_checked
);

  // One predicted result word
  typedef struct packed {
    motor_t     left;
    motor_t     right;
    logic [7:0] servo_x;
    logic [7:0] servo_y;
    logic       manual;
    ev_t        ev;
    logic [7:0] block;
  } drive_status_t;

  // Predicted register settings
  logic [7:0]       start_val;
  logic [7:0]       end_val;
  logic [6:0]       db_val;

  // Predicted block state
  logic [7:0]       frame_mem [FRAME_BYTES];
  logic [IDX_W-1:0] idx;
  motor_t           left_m;
  motor_t           right_m;
  logic [7:0]       servo_x;
  logic [7:0]       servo_y;
  logic             manual;

  drive_status_t    pending_status [$];

  task automatic report_mismatch(string msg);
    // keep the log readable when the block is badly broken
    if (mismatches < 100) $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got 0x%0h, expected 0x%0h",
                                words_checked, name, got, want));
  endtask

  // Clamp a mix value to +/-255 and split it into sign and magnitude
  function automatic motor_t to_motor(int v);
    motor_t m;
    if (v > 255) v = 255;
    else if (v < -255) v = -255;
    if (v >= 0) begin
      m.dir  = DIR_FWD;
      m.duty = 8'(v);
    end else begin
      m.dir  = DIR_BACK;
      m.duty = 8'(-v);
    end
    return m;
  endfunction

  // Run the stored frame as a command
  task automatic exec_frame(output ev_t ev);
    logic [15:0] instr;
    instr = {frame_mem[0], frame_mem[1]};
    ev    = EV_DONE;
    case (instr)
      CMD_LEFT_DUTY:  left_m.duty  = frame_mem[2];
      CMD_RIGHT_DUTY: right_m.duty = frame_mem[2];
      CMD_SERVO_X:    servo_x      = frame_mem[2];
      CMD_SERVO_Y:    servo_y      = frame_mem[2];
      CMD_EE_READ:    ev           = EV_EE_READ;
      CMD_EE_WRITE:   ev           = EV_EE_WRITE;
      CMD_MANUAL_ON:  manual       = 1'b1;
      CMD_MANUAL_OFF: manual       = 1'b0;
      default:        ev           = EV_UNKNOWN;
    endcase
  endtask

  // Advance the predicted state by one input word and queue the status it yields
  task automatic predict_word(input logic op, input logic [7:0] rx, t, r, jx, jy);
    drive_status_t s;
    ev_t           ev;
    logic [7:0]    blk;
    int            dt;
    int            dr;
    int            db;
    ev  = EV_NONE;
    blk = 8'h00;
    if (op == OP_BYTE) begin
      if (rx == start_val) begin
        // start always wins, even over the end byte
        idx = '0;
      end else if (rx == end_val && idx == FRAME_BYTES) begin
        exec_frame(ev);
        blk = frame_mem[2];
      end else if (idx < FRAME_BYTES) begin
        frame_mem[idx] = rx;
        idx            = idx + 1'b1;
      end
    end else if (manual) begin
      servo_x = jx;
      servo_y = jy;
      dt      = int'(t) - 128;
      dr      = int'(r) - 128;
      db      = int'(db_val);
      if ((dt < 0 ? -dt : dt) < db && (dr < 0 ? -dr : dr) < db) begin
        left_m  = '{duty: 8'h00, dir: DIR_STOP};
        right_m = '{duty: 8'h00, dir: DIR_STOP};
      end else begin
        left_m  = to_motor(dt - dr);
        right_m = to_motor(dt + dr);
      end
      ev = EV_JOY_OK;
    end else begin
      ev = EV_JOY_SKIP;
    end
    s.left    = left_m;
    s.right   = right_m;
    s.servo_x = servo_x;
    s.servo_y = servo_y;
    s.manual  = manual;
    s.ev      = ev;
    s.block   = blk;
    pending_status.push_back(s);
  endtask

  // Compare one accepted result word with the oldest prediction
  task automatic check_result();
    drive_status_t want;
    if (pending_status.size() == 0) begin
      report_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
    end else begin
      want = pending_status.pop_front();
      compare_field("left_duty",     out_mon.left_duty,      want.left.duty);
      compare_field("left_dir",      8'(out_mon.left_dir),   8'(want.left.dir));
      compare_field("right_duty",    out_mon.right_duty,     want.right.duty);
      compare_field("right_dir",     8'(out_mon.right_dir),  8'(want.right.dir));
      compare_field("servo_x_cmd",   out_mon.servo_x_cmd,    want.servo_x);
      compare_field("servo_y_cmd",   out_mon.servo_y_cmd,    want.servo_y);
      compare_field("manual_on",     8'(out_mon.manual_on),  8'(want.manual));
      compare_field("event_res",     8'(out_mon.event_res),  8'(want.ev));
      compare_field("request_block", out_mon.request_block,  want.block);
    end
    words_checked++;
  endtask

  // Sample every port at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      start_val = START_BYTE_RST;
      end_val   = END_BYTE_RST;
      db_val    = DEADBAND_RST;
      idx       = '0;
      left_m    = '{duty: 8'h00, dir: DIR_STOP};
      right_m   = '{duty: 8'h00, dir: DIR_STOP};
      servo_x   = SERVO_RST;
      servo_y   = SERVO_RST;
      manual    = 1'b1;
      pending_status.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_START_BYTE: start_val = cfg_wdata;
          CFG_END_BYTE:   end_val   = cfg_wdata;
          CFG_DEADBAND:   db_val    = cfg_wdata[6:0];
          default:        ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        predict_word(in_mon.op, in_mon.rx_byte, in_mon.joy_translate, in_mon.joy_rotate,
                     in_mon.joy_servo_x, in_mon.joy_servo_y);
    end
    outstanding <= pending_status.size();
  end

endmodule

// ===== verif/framed_command_differential_drive_tb.sv =====
// Testbench top for framed_command_differential_drive: drives frames, stray bytes and
// joystick words under random idling over several register settings; the checker
// beside the block predicts and compares. Depends on fcdd_pkg, fcdd_stream_if, checker.
`timescale 1ns / 1ps

module framed_command_differential_drive_tb;
  import fcdd_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_wdata;

  fcdd_in_if  in_ch ();
  fcdd_out_if out_ch ();

  int         mismatches;
  int         outstanding;
  int         words_checked;
  int         words_sent;
  int         settings_used;

  // Settings the stimulus builds frames from
  logic [7:0] cur_start;
  logic [7:0] cur_end;
  logic [6:0] cur_db;
  bit         idling = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  framed_command_differential_drive DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  fcdd_drive_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Axis sample: half uniform, half close to centre around the deadband edge
  function automatic logic [7:0] axis_sample();
    int span;
    if ($urandom_range(0, 1) == 1) return 8'($urandom());
    span = int'(cur_db) + 2;
    return 8'(128 - span + $urandom_range(0, 2 * span));
  endfunction

  // Instruction pair, weighted so manual mode is on most of the time
  function automatic logic [15:0] pick_instr();
    case ($urandom_range(0, 11))
      0, 9:    return CMD_LEFT_DUTY;
      1, 10:   return CMD_RIGHT_DUTY;
      2:       return CMD_SERVO_X;
      3:       return CMD_SERVO_Y;
      4:       return CMD_EE_READ;
      5:       return CMD_EE_WRITE;
      6, 7:    return CMD_MANUAL_ON;
      8:       return CMD_MANUAL_OFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Offer one word, optionally after a gap, and hold it until accepted
  task automatic drive_word(input logic op, input logic [7:0] rx, t, r, jx, jy);
    int gap;
    gap = (idling && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.rx_byte       <= rx;
    in_ch.joy_translate <= t;
    in_ch.joy_rotate    <= r;
    in_ch.joy_servo_x   <= jx;
    in_ch.joy_servo_y   <= jy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Serial byte word; the joystick fields carry noise
  task automatic send_byte(input logic [7:0] b);
    drive_word(OP_BYTE, b, 8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  // Joystick word; the serial byte carries noise
  task automatic send_joy(input logic [7:0] t, r, jx, jy);
    drive_word(OP_JOY, 8'($urandom()), t, r, jx, jy);
  endtask

  task automatic send_frame(input logic [15:0] instr, input logic [7:0] data);
    send_byte(cur_start);
    send_byte(instr[15:8]);
    send_byte(instr[7:0]);
    send_byte(data);
    send_byte(cur_end);
  endtask

  // Let every expected word drain, then hold the input idle before going on
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] s, e, input logic [6:0] d);
    write_reg(CFG_START_BYTE, s);
    write_reg(CFG_END_BYTE, e);
    // top bit of the deadband write is don't-care
    write_reg(CFG_DEADBAND, {1'($urandom_range(0, 1)), d});
    cur_start = s;
    cur_end   = e;
    cur_db    = d;
    settings_used++;
  endtask

  // Mostly well-formed frames with random content, plus joystick words and noise
  task automatic random_traffic(input int n);
    int          stop_at;
    int          pick;
    logic [15:0] instr;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 40) == 0) idling = !idling;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(pick_instr(), 8'($urandom()));
        if ($urandom_range(0, 5) == 0) send_byte(cur_end);
      end else if (pick < 80) begin
        send_joy(axis_sample(), axis_sample(), 8'($urandom()), 8'($urandom()));
      end else if (pick < 88) begin
        // frame abandoned part way
        send_byte(cur_start);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom()));
      end else if (pick < 94) begin
        // end byte lands in the second instruction slot
        instr = pick_instr();
        send_byte(cur_start);
        send_byte(instr[15:8]);
        send_byte(cur_end);
        send_byte(8'($urandom()));
        send_byte(cur_end);
      end else begin
        send_byte(8'($urandom()));
      end
    end
  endtask

  // Result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!idling || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() - 1) @(posedge clk);
      end
    end
  end

  // Main stimulus
  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_START_BYTE;
    cfg_wdata           <= 8'h00;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_BYTE;
    in_ch.rx_byte       <= 8'h00;
    in_ch.joy_translate <= 8'h00;
    in_ch.joy_rotate    <= 8'h00;
    in_ch.joy_servo_x   <= 8'h00;
    in_ch.joy_servo_y   <= 8'h00;
    cur_start           = START_BYTE_RST;
    cur_end             = END_BYTE_RST;
    cur_db              = DEADBAND_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings
    send_joy(8'd128, 8'd128, 8'h00, 8'hFF);  // centre stops both motors
    send_joy(8'hFF, 8'h00, 8'hFF, 8'h00);    // left clamps high, right just backward
    send_joy(8'h00, 8'h00, 8'h80, 8'h7F);    // left mix zero, right clamps at -255
    send_frame(CMD_LEFT_DUTY, 8'hFF);        // duty only, direction kept
    send_byte(cur_end);                      // repeated end runs the frame again
    send_byte(8'h77);                        // surplus byte is dropped
    send_byte(cur_start);                    // early end is stored, then manual off
    send_byte(8'h48);
    send_byte(8'h48);
    send_byte(cur_end);
    send_byte(cur_end);
    send_joy(8'h00, 8'hFF, 8'h12, 8'h34);    // ignored in automatic mode
    send_byte(cur_start);                    // start mid-frame restarts the frame
    send_byte(8'h47);
    send_frame(CMD_MANUAL_ON, 8'h00);
    send_frame(CMD_EE_READ, 8'h00);

    random_traffic(260);

    settle();
    set_config(8'h00, 8'hFF, 7'd0);          // zero deadband
    random_traffic(260);

    settle();
    set_config(8'hFF, 8'h00, 7'd127);        // widest deadband
    random_traffic(260);

    settle();
    set_config(8'h5A, 8'h5A, 7'd10);         // start equals end, no frame can run
    random_traffic(150);

    settle();
    set_config(8'($urandom()), 8'($urandom()), 7'($urandom()));
    random_traffic(250);

    settle();
    set_config(START_BYTE_RST, END_BYTE_RST, DEADBAND_RST);
    random_traffic(370);

    settle();
    $display("Checked %0d result words from %0d input words over %0d register settings",
             words_checked, words_sent, settings_used + 1);
    $display("Covered frames, stray and early end bytes, and joystick mixing in both modes");
    if (mismatches == 0) begin
      $display("framed_command_differential_drive_tb: PASS");
    end else begin
      $display("framed_command_differential_drive_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("Timed out with %0d words still expected", outstanding);
    $display("framed_command_differential_drive_tb: FAIL");
    $finish;
  end

endmodule
